>>> rtl/plps_pkg.sv
package plps_pkg;

	localparam int BASE_W = 20;
	localparam int HGT_W  = 16;
	localparam int AXIS_W = 16;
	localparam int CFG_W  = 24;
	localparam int IDX_W  = 3;
	localparam int PROD_W = AXIS_W + HGT_W;
	localparam int OFS_W  = 21;
	localparam int NRM_W  = 9;
	localparam int SQ_W   = 2 * OFS_W;
	localparam int LEN_W  = SQ_W / 2;
	localparam int DOTP_W = OFS_W + NRM_W;
	localparam int DOT_W  = 32;
	localparam int RAT_W  = LEN_W + CFG_W;
	localparam int FALL_W = 17;
	localparam int DIVD_W = DOT_W - 1 + 16;
	localparam int DIVS_W = LEN_W + 7;
	localparam int ANG_W  = 19;
	localparam int INT_W  = 19;
	localparam int CHP_W  = CFG_W + INT_W;

	localparam logic [FALL_W-1:0] ONE_Q16 = FALL_W'(65536);
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(8192);

	localparam logic signed [AXIS_W-1:0] UP_X_RST = 16'sd0;
	localparam logic signed [AXIS_W-1:0] UP_Y_RST = 16'sd0;
	localparam logic signed [AXIS_W-1:0] UP_Z_RST = 16'sd16384;
	localparam logic [CFG_W-1:0] INV_R_RST = 24'd65536;
	localparam logic [CFG_W-1:0] COLOR_RST = 24'd65280;

	typedef enum logic [IDX_W-1:0] {
		REG_UP_X    = 3'd0,
		REG_UP_Y    = 3'd1,
		REG_UP_Z    = 3'd2,
		REG_INV_R   = 3'd3,
		REG_COLOR_R = 3'd4,
		REG_COLOR_G = 3'd5,
		REG_COLOR_B = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic en;
		logic valid;
	} pctl_t;

	typedef struct packed {
		logic signed [DOT_W-1:0] dot;
		rgb_t                    old;
	} sqs_t;

	typedef struct packed {
		logic [FALL_W-1:0] fall;
		rgb_t              old;
	} dvs_t;

endpackage

>>> rtl/plps_in_if.sv
interface plps_in_if;
	logic                     valid;
	logic                     ready;
	logic signed [19:0]       base_x;
	logic signed [19:0]       base_y;
	logic signed [19:0]       base_z;
	logic signed [15:0]       height;
	logic [7:0]               normal_red;
	logic [7:0]               normal_green;
	logic [7:0]               normal_blue;
	logic [7:0]               old_red;
	logic [7:0]               old_green;
	logic [7:0]               old_blue;

	modport source (output valid, base_x, base_y, base_z, height, normal_red, normal_green,
		normal_blue, old_red, old_green, old_blue, input ready);
	modport sink (input valid, base_x, base_y, base_z, height, normal_red, normal_green,
		normal_blue, old_red, old_green, old_blue, output ready);
endinterface

>>> rtl/plps_out_if.sv
interface plps_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] light_red;
	logic [7:0] light_green;
	logic [7:0] light_blue;

	modport source (output valid, light_red, light_green, light_blue, input ready);
	modport sink (input valid, light_red, light_green, light_blue, output ready);
endinterface

>>> rtl/point_light_pixel_shading.sv
// an accepted pixel passes s1 to s4, the square root, sA, sB, the divider, sC, sD and sE before reaching res
// throughput: one pixel per cycle while res is not stalled; the 21-stage square root
// and the 19-stage divider each resolve one bit per stage, which sets the depth
// a stall on res holds every stage at once; pix.ready is low only while res is stalled
// reset: arst_n clears all valid bits and loads the register defaults
module point_light_pixel_shading (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [plps_pkg::IDX_W-1:0]      cfg_index,
	input  logic [plps_pkg::CFG_W-1:0]      cfg_data,
	plps_in_if.sink                         pix,
	plps_out_if.source                      res
);
	localparam int AW = plps_pkg::AXIS_W;
	localparam int CW = plps_pkg::CFG_W;
	localparam int PW = plps_pkg::PROD_W;
	localparam int OW = plps_pkg::OFS_W;
	localparam int NW = plps_pkg::NRM_W;

	// configuration
	logic signed [AW-1:0] up_x_q, up_y_q, up_z_q;
	logic [CW-1:0]        inv_r_q, col_r_q, col_g_q, col_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_x_q  <= plps_pkg::UP_X_RST;
			up_y_q  <= plps_pkg::UP_Y_RST;
			up_z_q  <= plps_pkg::UP_Z_RST;
			inv_r_q <= plps_pkg::INV_R_RST;
			col_r_q <= plps_pkg::COLOR_RST;
			col_g_q <= plps_pkg::COLOR_RST;
			col_b_q <= plps_pkg::COLOR_RST;
		end else if (cfg_wen) begin
			case (plps_pkg::reg_idx_t'(cfg_index))
				plps_pkg::REG_UP_X:    up_x_q  <= $signed(cfg_data[AW-1:0]);
				plps_pkg::REG_UP_Y:    up_y_q  <= $signed(cfg_data[AW-1:0]);
				plps_pkg::REG_UP_Z:    up_z_q  <= $signed(cfg_data[AW-1:0]);
				plps_pkg::REG_INV_R:   inv_r_q <= cfg_data;
				plps_pkg::REG_COLOR_R: col_r_q <= cfg_data;
				plps_pkg::REG_COLOR_G: col_g_q <= cfg_data;
				plps_pkg::REG_COLOR_B: col_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic            en;
	logic            out_v_sE;
	plps_pkg::pctl_t ctl_sq, ctl_dv;

	assign en        = !out_v_sE || res.ready;
	assign pix.ready = en;

	// s1: extrusion products
	logic                 v_s1;
	logic signed [PW-1:0] px_s1, py_s1, pz_s1;
	logic signed [19:0]   bx_s1, by_s1, bz_s1;
	logic signed [NW-1:0] nx_s1, ny_s1, nz_s1;
	plps_pkg::rgb_t       old_s1;

	// s2: offset
	logic                 v_s2;
	logic signed [OW-1:0] ox_s2, oy_s2, oz_s2;
	logic signed [NW-1:0] nx_s2, ny_s2, nz_s2;
	plps_pkg::rgb_t       old_s2;
	logic signed [PW-1:0] rx, ry, rz;

	// s3: squares and dot terms
	logic                                  v_s3;
	logic signed [plps_pkg::SQ_W-1:0]      sx_s3, sy_s3, sz_s3;
	logic signed [plps_pkg::DOTP_W-1:0]    dx_s3, dy_s3, dz_s3;
	plps_pkg::rgb_t                        old_s3;

	// s4: sums
	logic                                  v_s4;
	logic [plps_pkg::SQ_W-1:0]             sq_s4;
	plps_pkg::sqs_t                        side_s4;

	always_comb begin
		rx = (px_s1 + plps_pkg::ROUND_HALF) >>> 14;
		ry = (py_s1 + plps_pkg::ROUND_HALF) >>> 14;
		rz = (pz_s1 + plps_pkg::ROUND_HALF) >>> 14;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= up_x_q * pix.height;
			py_s1  <= up_y_q * pix.height;
			pz_s1  <= up_z_q * pix.height;
			bx_s1  <= pix.base_x;
			by_s1  <= pix.base_y;
			bz_s1  <= pix.base_z;
			nx_s1  <= $signed(NW'(128) - {1'b0, pix.normal_red});
			ny_s1  <= $signed(NW'(128) - {1'b0, pix.normal_green});
			nz_s1  <= $signed(NW'(128) - {1'b0, pix.normal_blue});
			old_s1 <= '{r: pix.old_red, g: pix.old_green, b: pix.old_blue};

			ox_s2  <= OW'(bx_s1) + OW'(rx);
			oy_s2  <= OW'(by_s1) + OW'(ry);
			oz_s2  <= OW'(bz_s1) + OW'(rz);
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			nz_s2  <= nz_s1;
			old_s2 <= old_s1;

			sx_s3  <= ox_s2 * ox_s2;
			sy_s3  <= oy_s2 * oy_s2;
			sz_s3  <= oz_s2 * oz_s2;
			dx_s3  <= ox_s2 * nx_s2;
			dy_s3  <= oy_s2 * ny_s2;
			dz_s3  <= oz_s2 * nz_s2;
			old_s3 <= old_s2;

			sq_s4       <= $unsigned(sx_s3) + $unsigned(sy_s3) + $unsigned(sz_s3);
			side_s4.dot <= plps_pkg::DOT_W'(dx_s3) + plps_pkg::DOT_W'(dy_s3)
				+ plps_pkg::DOT_W'(dz_s3);
			side_s4.old <= old_s3;
		end
	end

	// length
	logic                          v_sq;
	logic [plps_pkg::LEN_W-1:0]    len;
	plps_pkg::sqs_t                side_sq;

	assign ctl_sq = '{en: en, valid: v_s4};

	plps_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_sq),
		.sq       (sq_s4),
		.side_in  (side_s4),
		.valid    (v_sq),
		.len      (len),
		.side_out (side_sq)
	);

	// sA: ratio product, divider operands
	logic                            v_sA;
	logic [plps_pkg::RAT_W-1:0]      rat_sA;
	logic [plps_pkg::DIVD_W-1:0]     dvd_sA;
	logic [plps_pkg::DIVS_W-1:0]     dvs_sA;
	plps_pkg::rgb_t                  old_sA;

	// sB: falloff
	logic                            v_sB;
	logic [plps_pkg::DIVD_W-1:0]     dvd_sB;
	logic [plps_pkg::DIVS_W-1:0]     dvs_sB;
	plps_pkg::dvs_t                  side_sB;
	logic [plps_pkg::RAT_W-17:0]     rat_hi;
	logic [plps_pkg::FALL_W-1:0]     rat_c, rem1;
	logic [2*plps_pkg::FALL_W-1:0]   rem_sqr;

	always_comb begin
		rat_hi  = rat_sA[plps_pkg::RAT_W-1:16];
		rat_c   = (rat_hi > (plps_pkg::RAT_W-16)'(plps_pkg::ONE_Q16)) ? plps_pkg::ONE_Q16
			: rat_hi[plps_pkg::FALL_W-1:0];
		rem1    = plps_pkg::ONE_Q16 - rat_c;
		rem_sqr = rem1 * rem1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sA <= 1'b0;
			v_sB <= 1'b0;
		end else if (en) begin
			v_sA <= v_sq;
			v_sB <= v_sA;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rat_sA <= len * inv_r_q;
			// zero length or back facing gives a zero dividend and no light
			if (len != '0 && side_sq.dot > 0) begin
				dvd_sA <= {side_sq.dot[plps_pkg::DOT_W-2:0], 16'd0};
			end else begin
				dvd_sA <= '0;
			end
			dvs_sA <= (len == '0) ? plps_pkg::DIVS_W'(1) : {len, 7'd0};
			old_sA <= side_sq.old;

			dvd_sB       <= dvd_sA;
			dvs_sB       <= dvs_sA;
			side_sB.fall <= rem_sqr[16 +: plps_pkg::FALL_W];
			side_sB.old  <= old_sA;
		end
	end

	// angle factor
	logic                          v_dv;
	logic [plps_pkg::ANG_W-1:0]    ang;
	plps_pkg::dvs_t                side_dv;

	assign ctl_dv = '{en: en, valid: v_sB};

	plps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_dv),
		.dvd      (dvd_sB),
		.dvs      (dvs_sB),
		.side_in  (side_sB),
		.valid    (v_dv),
		.quo      (ang),
		.side_out (side_dv)
	);

	// sC: intensity, sD: channel products, sE: output register
	logic                                         v_sC, v_sD;
	logic [plps_pkg::INT_W-1:0]                   int_sC;
	logic [plps_pkg::ANG_W+plps_pkg::FALL_W-1:0]  int_full;
	plps_pkg::rgb_t                               old_sC, old_sD;
	logic [plps_pkg::CHP_W-1:0]                   cr_sD, cg_sD, cb_sD;
	logic [7:0]                                   lr_sE, lg_sE, lb_sE;

	function automatic logic [7:0] shade(input logic [plps_pkg::CHP_W-1:0] prod,
		input logic [7:0] old);
		logic [plps_pkg::CHP_W-25:0] add;
		logic [8:0]                  sum;
		add = prod[plps_pkg::CHP_W-1:24];
		sum = {1'b0, old} + ((add > (plps_pkg::CHP_W-24)'(255)) ? 9'd255 : {1'b0, add[7:0]});
		return sum[8] ? 8'd255 : sum[7:0];
	endfunction

	assign int_full = ang * side_dv.fall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sC     <= 1'b0;
			v_sD     <= 1'b0;
			out_v_sE <= 1'b0;
		end else if (en) begin
			v_sC     <= v_dv;
			v_sD     <= v_sC;
			out_v_sE <= v_sD;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			int_sC <= int_full[16 +: plps_pkg::INT_W];
			old_sC <= side_dv.old;

			cr_sD  <= col_r_q * int_sC;
			cg_sD  <= col_g_q * int_sC;
			cb_sD  <= col_b_q * int_sC;
			old_sD <= old_sC;

			lr_sE  <= shade(cr_sD, old_sD.r);
			lg_sE  <= shade(cg_sD, old_sD.g);
			lb_sE  <= shade(cb_sD, old_sD.b);
		end
	end

	assign res.valid       = out_v_sE;
	assign res.light_red   = lr_sE;
	assign res.light_green = lg_sE;
	assign res.light_blue  = lb_sE;
endmodule

>>> rtl/plps_isqrt.sv
module plps_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  plps_pkg::pctl_t               ctl,
	input  logic [plps_pkg::SQ_W-1:0]     sq,
	input  plps_pkg::sqs_t                side_in,
	output logic                          valid,
	output logic [plps_pkg::LEN_W-1:0]    len,
	output plps_pkg::sqs_t                side_out
);
	localparam int SW = plps_pkg::SQ_W;
	localparam int LW = plps_pkg::LEN_W;

	logic                 vld_s  [0:LW];
	logic [SW-1:0]        rem_s  [0:LW];
	logic [LW-1:0]        root_s [0:LW];
	plps_pkg::sqs_t       side_s [0:LW];

	assign vld_s[0]  = ctl.valid;
	assign rem_s[0]  = sq;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	// one result bit per stage, remainder kept as sq - root^2
	for (genvar k = 0; k < LW; k++) begin : g_bit
		localparam int B = LW - 1 - k;
		logic [SW:0] trial;

		always_comb begin
			trial = ((SW+1)'(root_s[k]) << (B + 1)) | ((SW+1)'(1) << (2 * B));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				if ({1'b0, rem_s[k]} >= trial) begin
					rem_s[k+1]  <= SW'({1'b0, rem_s[k]} - trial);
					root_s[k+1] <= root_s[k] | (LW'(1) << B);
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k];
				end
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign valid    = vld_s[LW];
	assign len      = root_s[LW];
	assign side_out = side_s[LW];
endmodule

>>> rtl/plps_div.sv
module plps_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  plps_pkg::pctl_t               ctl,
	input  logic [plps_pkg::DIVD_W-1:0]   dvd,
	input  logic [plps_pkg::DIVS_W-1:0]   dvs,
	input  plps_pkg::dvs_t                side_in,
	output logic                          valid,
	output logic [plps_pkg::ANG_W-1:0]    quo,
	output plps_pkg::dvs_t                side_out
);
	localparam int DW = plps_pkg::DIVD_W;
	localparam int VW = plps_pkg::DIVS_W;
	localparam int QW = plps_pkg::ANG_W;

	logic                 vld_s  [0:QW];
	logic [DW-1:0]        rem_s  [0:QW];
	logic [VW-1:0]        den_s  [0:QW];
	logic [QW-1:0]        quo_s  [0:QW];
	plps_pkg::dvs_t       side_s [0:QW];

	assign vld_s[0]  = ctl.valid;
	assign rem_s[0]  = dvd;
	assign den_s[0]  = dvs;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;

	// restoring division, one quotient bit per stage, msb first
	for (genvar k = 0; k < QW; k++) begin : g_bit
		localparam int B = QW - 1 - k;
		logic [DW:0] shifted;

		always_comb begin
			shifted = (DW+1)'(den_s[k]) << B;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				if ({1'b0, rem_s[k]} >= shifted) begin
					rem_s[k+1] <= DW'({1'b0, rem_s[k]} - shifted);
					quo_s[k+1] <= quo_s[k] | (QW'(1) << B);
				end else begin
					rem_s[k+1] <= rem_s[k];
					quo_s[k+1] <= quo_s[k];
				end
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign valid    = vld_s[QW];
	assign quo      = quo_s[QW];
	assign side_out = side_s[QW];
endmodule

>>> rtl/plps_checker.sv
module plps_checker (
	input logic        clk,
	input logic        arst_n,
	plps_in_if.sink    pix,
	plps_out_if.source res
);
	// pipeline only stalls while the output transaction waits
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		pix.ready == (!res.valid || res.ready))
		else $error("pix.ready does not follow the output stage");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> $stable(res.light_red) && $stable(res.light_green)
			&& $stable(res.light_blue))
		else $error("result changed while stalled");

	a_reset_empty: assert property (@(posedge clk)
		$past(!arst_n) |-> !res.valid)
		else $error("result valid straight after reset");
endmodule

bind point_light_pixel_shading plps_checker u_plps_checker (.*);

>>> tb/tb_top.sv
module tb_top;
	import plps_pkg::*;

	localparam int  DRAIN_CYCLES = 60;
	localparam int  CYCLE_LIMIT  = 400000;
	localparam int  RANDOM_ITEMS = 1900;
	// index past the last register, writes there must be ignored
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic signed [BASE_W-1:0] bx;
		logic signed [BASE_W-1:0] by;
		logic signed [BASE_W-1:0] bz;
		logic signed [HGT_W-1:0]  h;
		logic [7:0]               nr;
		logic [7:0]               ng;
		logic [7:0]               nb;
		rgb_t                     old;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	plps_in_if  pix ();
	plps_out_if res ();

	point_light_pixel_shading uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.res       (res)
	);

	// shadow copy of the light registers
	logic signed [AXIS_W-1:0] up_x, up_y, up_z;
	logic [CFG_W-1:0]         inv_r, col_r, col_g, col_b;

	rgb_t   expected_light[$];
	int     fails;
	int     cycles;
	bit     idle_on;
	int     res_stall;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	function automatic longint int_sqrt(input longint v);
		longint r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [7:0] mix_channel(input longint col, input longint inten,
		input logic [7:0] old);
		longint a, s;
		a = (col * inten) >> 24;
		if (a > 255)
			a = 255;
		s = longint'(old) + a;
		return (s > 255) ? 8'd255 : s[7:0];
	endfunction

	function automatic rgb_t shade_pixel(input pixel_t p);
		longint h, ox, oy, oz, sq, len, dot, ratio, fall, ang, inten;
		rgb_t o;
		h  = longint'(p.h);
		ox = longint'(p.bx) + ((longint'(up_x) * h + 8192) >>> 14);
		oy = longint'(p.by) + ((longint'(up_y) * h + 8192) >>> 14);
		oz = longint'(p.bz) + ((longint'(up_z) * h + 8192) >>> 14);
		sq = ox * ox + oy * oy + oz * oz;
		len = int_sqrt(sq);
		dot = ox * (128 - longint'(p.nr)) + oy * (128 - longint'(p.ng))
			+ oz * (128 - longint'(p.nb));
		ratio = (len * longint'(inv_r)) >> 16;
		if (ratio > 65536)
			ratio = 65536;
		fall = ((65536 - ratio) * (65536 - ratio)) >> 16;
		if (len == 0 || dot <= 0)
			ang = 0;
		else
			ang = (dot <<< 16) / (len * 128);
		inten = (ang * fall) >> 16;
		o.r = mix_channel(longint'(col_r), inten, p.old.r);
		o.g = mix_channel(longint'(col_g), inten, p.old.g);
		o.b = mix_channel(longint'(col_b), inten, p.old.b);
		return o;
	endfunction

	// result side: compare and draw the next stall
	always @(posedge clk) begin
		rgb_t want;
		if (res.valid && res.ready) begin
			if (expected_light.size() == 0) begin
				report_mismatch("unexpected transaction", 0, 0);
			end else begin
				want = expected_light.pop_front();
				if (res.light_red !== want.r)
					report_mismatch("light_red", int'(res.light_red), int'(want.r));
				if (res.light_green !== want.g)
					report_mismatch("light_green", int'(res.light_green), int'(want.g));
				if (res.light_blue !== want.b)
					report_mismatch("light_blue", int'(res.light_blue), int'(want.b));
			end
			res_stall <= idle_on ? $urandom_range(0, 8) : 0;
		end else if (res_stall > 0) begin
			res_stall <= res_stall - 1;
		end
	end

	always @(negedge clk) begin
		res.ready <= (res_stall == 0);
	end

	// called just after a falling edge, returns just after one
	task automatic send_pixel(input pixel_t p);
		int gap;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix.base_x       <= p.bx;
		pix.base_y       <= p.by;
		pix.base_z       <= p.bz;
		pix.height       <= p.h;
		pix.normal_red   <= p.nr;
		pix.normal_green <= p.ng;
		pix.normal_blue  <= p.nb;
		pix.old_red      <= p.old.r;
		pix.old_green    <= p.old.g;
		pix.old_blue     <= p.old.b;
		pix.valid        <= 1'b1;
		do
			@(posedge clk);
		while (!pix.ready);
		expected_light.push_back(shade_pixel(p));
		@(negedge clk);
	endtask

	task automatic drain();
		pix.valid <= 1'b0;
		while (expected_light.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		case (idx)
			REG_UP_X:    up_x  = d[AXIS_W-1:0];
			REG_UP_Y:    up_y  = d[AXIS_W-1:0];
			REG_UP_Z:    up_z  = d[AXIS_W-1:0];
			REG_INV_R:   inv_r = d;
			REG_COLOR_R: col_r = d;
			REG_COLOR_G: col_g = d;
			REG_COLOR_B: col_b = d;
			default: ;
		endcase
	endtask

	function automatic pixel_t make_pixel(input int bx, input int by, input int bz,
		input int h, input int nr, input int ng, input int nb, input int o);
		pixel_t p;
		p.bx = BASE_W'(bx); p.by = BASE_W'(by); p.bz = BASE_W'(bz); p.h = HGT_W'(h);
		p.nr = 8'(nr); p.ng = 8'(ng); p.nb = 8'(nb);
		p.old.r = 8'(o); p.old.g = 8'(o); p.old.b = 8'(o);
		return p;
	endfunction

	// offsets of every magnitude so that many pixels fall inside the radius
	function automatic logic signed [BASE_W-1:0] rand_offset();
		logic signed [BASE_W-1:0] v;
		v = BASE_W'($urandom);
		return v >>> $urandom_range(0, 19);
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		logic signed [HGT_W-1:0] hv;
		p.bx = rand_offset();
		p.by = rand_offset();
		p.bz = rand_offset();
		hv = HGT_W'($urandom);
		p.h = ($urandom_range(0, 3) == 0) ? hv : hv >>> $urandom_range(4, 15);
		p.nr = 8'($urandom); p.ng = 8'($urandom); p.nb = 8'($urandom);
		p.old = 24'($urandom);
		return p;
	endfunction

	function automatic logic [CFG_W-1:0] rand_cfg();
		logic [CFG_W-1:0] v;
		v = CFG_W'($urandom);
		return v >> $urandom_range(0, 23);
	endfunction

	task automatic test_directed();
		idle_on = 1'b0;
		// zero-length offset
		send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 17));
		// facing the light, in range
		send_pixel(make_pixel(0, 0, 2560, 0, 128, 128, 0, 0));
		send_pixel(make_pixel(1000, -700, 300, 0, 0, 255, 100, 40));
		// back facing
		send_pixel(make_pixel(0, 0, 2560, 0, 128, 128, 255, 0));
		send_pixel(make_pixel(500, 0, 0, 0, 128, 128, 128, 9));
		// beyond the radius
		send_pixel(make_pixel(70000, 0, 0, 0, 0, 128, 128, 3));
		// field extremes
		send_pixel(make_pixel(524287, 524287, 524287, 32767, 0, 0, 0, 255));
		send_pixel(make_pixel(-524288, -524288, -524288, -32768, 255, 255, 255, 0));
		send_pixel(make_pixel(-524288, 524287, 0, -32768, 255, 0, 128, 200));
		// height alone moves the offset off zero
		send_pixel(make_pixel(0, 0, 0, 512, 128, 128, 0, 0));
		send_pixel(make_pixel(0, 0, 0, -512, 128, 128, 255, 0));
		send_pixel(make_pixel(3, -2, 1, 1, 0, 255, 0, 250));
		drain();
	endtask

	task automatic test_extreme_config();
		// huge red and green colours so those channels cap, blue is zero
		cfg_write(REG_COLOR_R, 24'hFFFFFF);
		cfg_write(REG_COLOR_G, 24'hFFFFFF);
		cfg_write(REG_COLOR_B, 24'h000000);
		cfg_write(REG_INV_R, 24'h000000);
		cfg_write(REG_UP_X, 24'h008000);
		cfg_write(REG_UP_Y, 24'h007FFF);
		cfg_write(REG_UP_Z, 24'hFF8000);
		cfg_write(REG_UNUSED, 24'h123456);
		send_pixel(make_pixel(0, 0, 2560, 0, 128, 128, 0, 0));
		send_pixel(make_pixel(100, 100, 100, 32767, 0, 0, 0, 100));
		send_pixel(make_pixel(-5, 7, 0, -32768, 255, 0, 200, 250));
		send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 1));
		drain();
		cfg_write(REG_INV_R, 24'hFFFFFF);
		cfg_write(REG_UP_X, 24'h007FFF);
		cfg_write(REG_UP_Z, 24'h000000);
		send_pixel(make_pixel(1, 0, 0, 0, 0, 128, 128, 0));
		send_pixel(make_pixel(300, 0, 0, 0, 0, 128, 128, 0));
		send_pixel(make_pixel(0, 0, 0, 1, 0, 128, 128, 60));
		drain();
	endtask

	task automatic test_random();
		int n, phase;
		n = 0;
		phase = 0;
		while (n < RANDOM_ITEMS) begin
			idle_on = (phase % 3) != 2;
			if (phase > 0) begin
				cfg_write(REG_UP_X, ($urandom_range(0, 1) != 0) ? CFG_W'($urandom) : '0);
				cfg_write(REG_UP_Y, ($urandom_range(0, 1) != 0) ? CFG_W'($urandom) : '0);
				cfg_write(REG_UP_Z, CFG_W'($urandom));
				cfg_write(REG_INV_R, rand_cfg());
				cfg_write(REG_COLOR_R, rand_cfg());
				cfg_write(REG_COLOR_G, rand_cfg());
				cfg_write(REG_COLOR_B, rand_cfg());
			end
			repeat (200) begin
				send_pixel(rand_pixel());
				n++;
			end
			drain();
			phase++;
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_wen    = 1'b0;
		cfg_index  = REG_UP_X;
		cfg_data   = '0;
		pix.valid  = 1'b0;
		pix.base_x = '0; pix.base_y = '0; pix.base_z = '0; pix.height = '0;
		pix.normal_red = '0; pix.normal_green = '0; pix.normal_blue = '0;
		pix.old_red = '0; pix.old_green = '0; pix.old_blue = '0;
		idle_on    = 1'b0;
		up_x  = UP_X_RST;
		up_y  = UP_Y_RST;
		up_z  = UP_Z_RST;
		inv_r = INV_R_RST;
		col_r = COLOR_RST;
		col_g = COLOR_RST;
		col_b = COLOR_RST;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_extreme_config();
		test_random();
		drain();
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
